// ----- hdl/cse_pkg.sv -----
// Shared types, constants and the evaluation micro-program of the cubic spline evaluator.
package cse_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int FRAC_BITS = 16;
    localparam int KIDX_W    = $clog2(MAX_KNOTS);
    localparam int ROW_W     = $clog2(MAX_KNOTS + 1);
    localparam int DX_W      = 33;
    // worst case c3*dx^3 plus headroom for the added terms
    localparam int ACC_W     = 3 * DX_W + 32 + 5;
    localparam int BIT_W     = $clog2(DX_W);
    localparam int PROG_LEN  = 20;
    localparam int PC_W      = $clog2(PROG_LEN);

    localparam logic [1:0] CMD_LOAD_KNOT = 2'd0;
    localparam logic [1:0] CMD_LOAD_ROW  = 2'd1;
    localparam logic [1:0] CMD_EVAL      = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_MUL  = 2'd1,
        OP_ADD  = 2'd2,
        OP_SAT  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        T_C3    = 3'd0,
        T_C3X3  = 3'd1,
        T_C3X6  = 3'd2,
        T_C2F   = 3'd3,
        T_C2X2F = 3'd4,
        T_C1F2  = 3'd5,
        T_C0F3  = 3'd6
    } term_t;

    typedef enum logic [1:0] {
        D_VALUE = 2'd0,
        D_SLOPE = 2'd1,
        D_CURV  = 2'd2,
        D_THIRD = 2'd3
    } dst_t;

    typedef struct packed {
        op_t   op;
        term_t term;
        dst_t  dst;
        logic  last;
    } uop_t;

    typedef struct packed {
        logic wr_knot;
        logic wr_row;
        logic capture;
        logic search_issue;
        logic dx_load;
        logic exec;
        logic mul_start;
        logic out_load;
        uop_t uop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic search_last;
        logic mul_done;
        logic out_busy;
    } dp_sts_t;

    // Horner sequences for value, slope, curvature and third derivative
    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        uop_t u;
        u = '{op: OP_MUL, term: T_C3, dst: D_VALUE, last: 1'b0};
        unique case (pc)
            5'd0:  u = '{op: OP_LOAD, term: T_C3,    dst: D_VALUE, last: 1'b0};
            5'd1:  u = '{op: OP_MUL,  term: T_C3,    dst: D_VALUE, last: 1'b0};
            5'd2:  u = '{op: OP_ADD,  term: T_C2F,   dst: D_VALUE, last: 1'b0};
            5'd3:  u = '{op: OP_MUL,  term: T_C3,    dst: D_VALUE, last: 1'b0};
            5'd4:  u = '{op: OP_ADD,  term: T_C1F2,  dst: D_VALUE, last: 1'b0};
            5'd5:  u = '{op: OP_MUL,  term: T_C3,    dst: D_VALUE, last: 1'b0};
            5'd6:  u = '{op: OP_ADD,  term: T_C0F3,  dst: D_VALUE, last: 1'b0};
            5'd7:  u = '{op: OP_SAT,  term: T_C3,    dst: D_VALUE, last: 1'b0};
            5'd8:  u = '{op: OP_LOAD, term: T_C3X3,  dst: D_SLOPE, last: 1'b0};
            5'd9:  u = '{op: OP_MUL,  term: T_C3,    dst: D_SLOPE, last: 1'b0};
            5'd10: u = '{op: OP_ADD,  term: T_C2X2F, dst: D_SLOPE, last: 1'b0};
            5'd11: u = '{op: OP_MUL,  term: T_C3,    dst: D_SLOPE, last: 1'b0};
            5'd12: u = '{op: OP_ADD,  term: T_C1F2,  dst: D_SLOPE, last: 1'b0};
            5'd13: u = '{op: OP_SAT,  term: T_C3,    dst: D_SLOPE, last: 1'b0};
            5'd14: u = '{op: OP_LOAD, term: T_C3X6,  dst: D_CURV,  last: 1'b0};
            5'd15: u = '{op: OP_MUL,  term: T_C3,    dst: D_CURV,  last: 1'b0};
            5'd16: u = '{op: OP_ADD,  term: T_C2X2F, dst: D_CURV,  last: 1'b0};
            5'd17: u = '{op: OP_SAT,  term: T_C3,    dst: D_CURV,  last: 1'b0};
            5'd18: u = '{op: OP_LOAD, term: T_C3X6,  dst: D_THIRD, last: 1'b0};
            5'd19: u = '{op: OP_SAT,  term: T_C3,    dst: D_THIRD, last: 1'b1};
            default: u = '{op: OP_SAT, term: T_C3,   dst: D_THIRD, last: 1'b1};
        endcase
        return u;
    endfunction

endpackage

// ----- hdl/cse_ctrl.sv -----
// Controller state machine: request decode, knot search sequencing and micro-program stepping.
module cse_ctrl
    import cse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic [1:0] req_command,
    input  logic [6:0] req_index,
    output logic      req_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_LAST   = 8'b0000_0100,
        S_ADDR   = 8'b0000_1000,
        S_DX     = 8'b0001_0000,
        S_EXEC   = 8'b0010_0000,
        S_MULW   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uop_t            uop;

    assign uop       = prog(pc_reg);
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd        = '0;
        cmd.uop    = uop;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_command)
                        CMD_LOAD_KNOT: cmd.wr_knot = (req_index < 7'(MAX_KNOTS));
                        CMD_LOAD_ROW:  cmd.wr_row  = (req_index <= 7'(MAX_KNOTS));
                        CMD_EVAL:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.search_issue = 1'b1;
                if (sts.search_last)
                    state_next = S_LAST;
            end
            S_LAST: state_next = S_ADDR;
            S_ADDR: state_next = S_DX;
            S_DX:
            begin
                cmd.dx_load = 1'b1;
                pc_next     = '0;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (uop.op == OP_MUL)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MULW;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    pc_next  = pc_reg + 1'b1;
                    if (uop.last)
                        state_next = S_DONE;
                end
            end
            S_MULW:
            begin
                if (sts.mul_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

// ----- hdl/cse_datapath.sv -----
// Datapath: knot and coefficient memories, search counter, serial multiplier, saturation, output register.
module cse_datapath
    import cse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_sts_t             sts,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic [6:0]          entry_index,
    input  logic signed [31:0]  x_value,
    input  logic signed [31:0]  coef_const,
    input  logic signed [31:0]  coef_linear,
    input  logic signed [31:0]  coef_square,
    input  logic signed [31:0]  coef_cube,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  value_out,
    output logic signed [31:0]  slope_out,
    output logic signed [31:0]  curvature_out,
    output logic signed [31:0]  third_out,
    output logic [6:0]          segment_out,
    output logic                saturated
);

    logic [31:0]  knot_mem [MAX_KNOTS];
    logic [127:0] coef_mem [MAX_KNOTS+1];

    logic [6:0]            kiu_reg;
    logic [6:0]            n_eff;
    logic signed [31:0]    x_reg;
    logic [KIDX_W-1:0]     k_reg;
    logic                  pend_reg;
    logic [ROW_W-1:0]      seg_reg;
    logic [KIDX_W-1:0]     knot_addr;
    logic [ROW_W-1:0]      seg_m1;
    logic signed [31:0]    knot_rd_reg;
    logic [127:0]          coef_rd_reg;
    logic signed [DX_W-1:0] dx_reg;
    logic signed [ACC_W-1:0] acc_reg, prod_reg, term, addend, shifted;
    logic [BIT_W-1:0]      bit_reg;
    logic                  mul_busy_reg;
    logic signed [31:0]    c0, c1, c2, c3;
    logic signed [ACC_W-1:0] c3w, c2w;
    logic signed [31:0]    sat_val;
    logic                  ovf;
    logic signed [31:0]    r_value_reg, r_slope_reg, r_curv_reg, r_third_reg;
    logic                  r_sat_reg;

    // knots_in_use clamped to 2..MAX_KNOTS
    always_comb
    begin
        if (kiu_reg < 7'd2)
            n_eff = 7'd2;
        else if (kiu_reg > 7'(MAX_KNOTS))
            n_eff = 7'(MAX_KNOTS);
        else
            n_eff = kiu_reg;
    end

    assign sts.search_last = (7'(k_reg) == n_eff - 7'd1);
    assign sts.mul_done    = mul_busy_reg && (bit_reg == '0);
    assign sts.out_busy    = out_valid && !out_ready;

    assign seg_m1    = (seg_reg == '0) ? '0 : seg_reg - 1'b1;
    assign knot_addr = cmd.search_issue ? k_reg : seg_m1[KIDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_knot)
            knot_mem[entry_index[KIDX_W-1:0]] <= x_value;
        if (cmd.wr_row)
            coef_mem[entry_index[ROW_W-1:0]] <= {coef_cube, coef_square, coef_linear, coef_const};
        knot_rd_reg <= knot_mem[knot_addr];
        coef_rd_reg <= coef_mem[seg_reg];
    end

    assign c0  = coef_rd_reg[31:0];
    assign c1  = coef_rd_reg[63:32];
    assign c2  = coef_rd_reg[95:64];
    assign c3  = coef_rd_reg[127:96];
    assign c3w = ACC_W'(c3);
    assign c2w = ACC_W'(c2);

    always_comb
    begin
        case (cmd.uop.term)
            T_C3:    term = c3w;
            T_C3X3:  term = (c3w <<< 1) + c3w;
            T_C3X6:  term = ((c3w <<< 1) + c3w) <<< 1;
            T_C2F:   term = c2w <<< FRAC_BITS;
            T_C2X2F: term = c2w <<< (FRAC_BITS + 1);
            T_C1F2:  term = ACC_W'(c1) <<< (2 * FRAC_BITS);
            T_C0F3:  term = ACC_W'(c0) <<< (3 * FRAC_BITS);
            default: term = c3w;
        endcase
    end

    always_comb
    begin
        case (cmd.uop.dst)
            D_VALUE: shifted = acc_reg >>> (3 * FRAC_BITS);
            D_SLOPE: shifted = acc_reg >>> (2 * FRAC_BITS);
            D_CURV:  shifted = acc_reg >>> FRAC_BITS;
            default: shifted = acc_reg;
        endcase
        ovf = !((&shifted[ACC_W-1:31]) || !(|shifted[ACC_W-1:31]));
        if (ovf)
            sat_val = shifted[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sat_val = shifted[31:0];
    end

    // shift-add multiply, dx MSB first; the sign bit weighs negative
    always_comb
    begin
        if (dx_reg[bit_reg])
            addend = (bit_reg == BIT_W'(DX_W - 1)) ? -acc_reg : acc_reg;
        else
            addend = '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            x_reg <= x_value;
        if (cmd.dx_load)
            dx_reg <= DX_W'(x_reg) - DX_W'(knot_rd_reg);
        if (cmd.mul_start)
        begin
            prod_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            prod_reg <= (prod_reg <<< 1) + addend;
            if (bit_reg == '0)
                acc_reg <= (prod_reg <<< 1) + addend;
        end
        if (cmd.exec)
        begin
            case (cmd.uop.op)
                OP_LOAD: acc_reg <= term;
                OP_ADD:  acc_reg <= acc_reg + term;
                OP_SAT:
                begin
                    case (cmd.uop.dst)
                        D_VALUE: r_value_reg <= sat_val;
                        D_SLOPE: r_slope_reg <= sat_val;
                        D_CURV:  r_curv_reg  <= sat_val;
                        default: r_third_reg <= sat_val;
                    endcase
                end
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            value_out     <= r_value_reg;
            slope_out     <= r_slope_reg;
            curvature_out <= r_curv_reg;
            third_out     <= r_third_reg;
            segment_out   <= 7'(seg_reg);
            saturated     <= r_sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kiu_reg      <= 7'd2;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            seg_reg      <= '0;
            mul_busy_reg <= 1'b0;
            bit_reg      <= '0;
            r_sat_reg    <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                kiu_reg <= cfg_wr_data;
            pend_reg <= cmd.search_issue;
            if (cmd.capture)
            begin
                k_reg   <= '0;
                seg_reg <= '0;
            end
            else
            begin
                if (cmd.search_issue)
                    k_reg <= k_reg + 1'b1;
                if (pend_reg && (knot_rd_reg <= x_reg))
                    seg_reg <= seg_reg + 1'b1;
            end
            if (cmd.mul_start)
            begin
                mul_busy_reg <= 1'b1;
                bit_reg      <= BIT_W'(DX_W - 1);
            end
            else if (mul_busy_reg)
            begin
                if (bit_reg == '0)
                    mul_busy_reg <= 1'b0;
                else
                    bit_reg <= bit_reg - 1'b1;
            end
            if (cmd.dx_load)
                r_sat_reg <= 1'b0;
            else if (cmd.exec && cmd.uop.op == OP_SAT && ovf)
                r_sat_reg <= 1'b1;
            if (cmd.out_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

endmodule

// ----- hdl/cubic_spline_evaluator.sv -----
// Top level of the piecewise cubic spline evaluator.
// Piecewise cubic spline evaluator, Q16.16. Requests on the slave stream carry a command in
// s_tuser: load knot (writes x_value at entry_index, 0..63), load coefficient row (writes the
// four coefficients at row entry_index, 0..64) or evaluate. Loads give no result;
// out-of-range loads and command 3 are dropped. An evaluate request counts the first
// knots_in_use knots (clamped to 2..64) that are <= x to find the segment, forms dx from the
// preceding knot (knot 0 for segment 0), then runs a shared shift-add multiplier through a
// Horner micro-program for value, slope, curvature and third derivative, and saturates each to
// 32 bits. An evaluate searches the knots (one knot memory read per cycle), then runs six
// multiplications and 14 further program steps, and then loads the output register. One
// evaluate is worked on at a time; the next request is taken as soon as the result sits in
// the output register, even if the master side has not taken it.
// Knots and rows read before being written return undefined data. knots_in_use is written
// through cfg_wr_en/cfg_wr_data and resets to 2; the user must write it only while idle, as
// the block itself does not enforce this.
module cubic_spline_evaluator
    import cse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,    // knots_in_use
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,        // command
    // [6:0] entry_index, [38:7] x_value, [70:39] coef_const, [102:71] coef_linear,
    // [134:103] coef_square, [166:135] coef_cube, [167] zero
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,        // saturated
    // [31:0] value_out, [63:32] slope_out, [95:64] curvature_out, [127:96] third_out,
    // [134:128] segment_out, [135] zero
    output logic [135:0] m_tdata
);

    ctrl_cmd_t          cmd;
    dp_sts_t            sts;
    logic signed [31:0] value_w, slope_w, curv_w, third_w;
    logic [6:0]         seg_w;

    // request decode and sequencing
    cse_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_command (s_tuser),
        .req_index   (s_tdata[6:0]),
        .req_ready   (s_tready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // memories, arithmetic and result register
    cse_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .entry_index   (s_tdata[6:0]),
        .x_value       (s_tdata[38:7]),
        .coef_const    (s_tdata[70:39]),
        .coef_linear   (s_tdata[102:71]),
        .coef_square   (s_tdata[134:103]),
        .coef_cube     (s_tdata[166:135]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .value_out     (value_w),
        .slope_out     (slope_w),
        .curvature_out (curv_w),
        .third_out     (third_w),
        .segment_out   (seg_w),
        .saturated     (m_tuser)
    );

    assign m_tdata = {1'b0, seg_w, third_w, curv_w, slope_w, value_w};

endmodule

// ----- tb/sv/cubic_spline_evaluator_tb.sv -----
// Self-checking testbench for the cubic spline evaluator: table-driven directed requests, then random.
`timescale 1ns / 100ps

module cubic_spline_evaluator_tb
    import cse_pkg::*;
();

    // request code that the block must drop
    localparam logic [1:0] CMD_NONE = 2'd3;
    // cycle limit for the whole run before the bench reports a timeout
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int SETTLE      = 20;
    localparam int PHASE_REQS  = 195;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] slope;
        logic [31:0] curv;
        logic [31:0] third;
        logic [6:0]  seg;
        logic        sat;
    } spline_res_t;

    // one row of the directed table; typed = 1 means the expected result is written in
    typedef struct packed {
        logic [1:0]  cmd;
        logic [6:0]  idx;
        logic [31:0] x;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        bit          typed;
        spline_res_t want;
    } dir_req_t;

    localparam spline_res_t NONE = '0;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [6:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;        // command
    // [6:0] entry_index, [38:7] x_value, [70:39] coef_const, [102:71] coef_linear,
    // [134:103] coef_square, [166:135] coef_cube, [167] zero
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         m_tuser;        // saturated
    // [31:0] value_out, [63:32] slope_out, [95:64] curvature_out, [127:96] third_out,
    // [134:128] segment_out, [135] zero
    logic [135:0] m_tdata;

    // mirror of the block's tables and register
    logic signed [31:0] knot_mem [MAX_KNOTS];
    logic signed [31:0] row_mem  [MAX_KNOTS + 1][4];
    logic [6:0]         knot_count;

    spline_res_t pending_q [$];
    int errors;
    int n_eval, n_load, n_drop, n_checked, n_sat;
    int cycles;
    bit gaps_on;
    bit hold_req;
    int knot_step;

    cubic_spline_evaluator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // clip a wide product to 32 bits; anything not a plain sign extension overflowed
    function automatic logic [31:0] clip32(input logic signed [199:0] v, inout logic flag);
        if (v[199:31] != {169{v[199]}})
        begin
            flag = 1'b1;
            return v[199] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // segment search plus exact Horner evaluation, then floor shift and clip
    function automatic spline_res_t spline_at(input logic signed [31:0] x);
        spline_res_t r;
        int n;
        int seg;
        longint dx;
        logic signed [199:0] d, a, k0, k1, k2, k3;
        logic flag;
        n = (knot_count < 2) ? 2 : (knot_count > MAX_KNOTS ? MAX_KNOTS : knot_count);
        seg = 0;
        for (int k = 0; k < n; k++)
            if (knot_mem[k] <= x)
                seg++;
        dx = longint'(x) - longint'(knot_mem[(seg == 0) ? 0 : seg - 1]);
        d  = dx;
        k0 = row_mem[seg][0];
        k1 = row_mem[seg][1];
        k2 = row_mem[seg][2];
        k3 = row_mem[seg][3];
        flag = 1'b0;

        a = k3 * d + (k2 <<< FRAC_BITS);
        a = a * d + (k1 <<< (2 * FRAC_BITS));
        a = a * d + (k0 <<< (3 * FRAC_BITS));
        r.value = clip32(a >>> (3 * FRAC_BITS), flag);

        a = 3 * k3 * d + ((2 * k2) <<< FRAC_BITS);
        a = a * d + (k1 <<< (2 * FRAC_BITS));
        r.slope = clip32(a >>> (2 * FRAC_BITS), flag);

        a = 6 * k3 * d + ((2 * k2) <<< FRAC_BITS);
        r.curv = clip32(a >>> FRAC_BITS, flag);

        r.third = clip32(6 * k3, flag);
        r.seg   = seg[6:0];
        r.sat   = flag;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch on %s: expected %h, got %h (result %0d)", what, want, got, n_checked);
        errors++;
    endtask

    // Offer one request; on acceptance update the mirror and queue what an evaluate must give.
    task automatic offer(input logic [1:0] cmd, input logic [6:0] idx, input logic [31:0] x,
                         input logic [31:0] c0, input logic [31:0] c1, input logic [31:0] c2,
                         input logic [31:0] c3, input bit typed, input spline_res_t want);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, c3, c2, c1, c0, x, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (cmd)
            CMD_LOAD_KNOT:
            begin
                if (idx < MAX_KNOTS)
                begin
                    knot_mem[idx] = x;
                    n_load++;
                end
                else
                    n_drop++;
            end
            CMD_LOAD_ROW:
            begin
                if (idx <= MAX_KNOTS)
                begin
                    row_mem[idx][0] = c0;
                    row_mem[idx][1] = c1;
                    row_mem[idx][2] = c2;
                    row_mem[idx][3] = c3;
                    n_load++;
                end
                else
                    n_drop++;
            end
            CMD_EVAL:
            begin
                pending_q.push_back(typed ? want : spline_at(x));
                n_eval++;
            end
            default: n_drop++;
        endcase
    endtask

    // register write only once the block has drained
    task automatic set_knot_count(input logic [6:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        knot_count = v;
    endtask

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    endfunction

    // sorted knots with a fresh spacing, plus every coefficient row
    task automatic load_tables();
        int base;
        knot_step = $urandom_range(16, 1 << 18);
        base = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        for (int k = 0; k < MAX_KNOTS; k++)
            offer(CMD_LOAD_KNOT, 7'(k), 32'(base + k * knot_step), '0, '0, '0, '0, 0, NONE);
        for (int r = 0; r <= MAX_KNOTS; r++)
            offer(CMD_LOAD_ROW, 7'(r), $urandom, rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), 0, NONE);
    endtask

    task automatic random_request();
        int pick;
        int k;
        logic [31:0] x;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, MAX_KNOTS - 1);
        if (pick < 50)
        begin
            // mostly near a knot so every segment gets hit, sometimes anywhere
            case ($urandom_range(0, 3))
                0:       x = $urandom;
                1:       x = knot_mem[k];
                default: x = knot_mem[k] + 32'(int'($urandom_range(0, 2 * knot_step))
                                               - knot_step);
            endcase
            offer(CMD_EVAL, 7'($urandom), x, $urandom, $urandom, $urandom, $urandom, 0, NONE);
        end
        else if (pick < 65)
        begin
            // nudge a knot, occasionally out of order
            x = knot_mem[k] + 32'(int'($urandom_range(0, knot_step)) - knot_step / 2);
            if ($urandom_range(0, 9) == 0)
                x = $urandom;
            offer(CMD_LOAD_KNOT, 7'(k), x, $urandom, $urandom, $urandom, $urandom, 0, NONE);
        end
        else if (pick < 87)
            offer(CMD_LOAD_ROW, 7'($urandom_range(0, MAX_KNOTS)), $urandom, rand_coef(),
                  rand_coef(), rand_coef(), rand_coef(), 0, NONE);
        else if (pick < 92)
            offer(CMD_NONE, 7'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                  0, NONE);
        else if (pick < 96)
            offer(CMD_LOAD_KNOT, 7'($urandom_range(MAX_KNOTS, 127)), $urandom, $urandom,
                  $urandom, $urandom, $urandom, 0, NONE);
        else
            offer(CMD_LOAD_ROW, 7'($urandom_range(MAX_KNOTS + 1, 127)), $urandom, $urandom,
                  $urandom, $urandom, $urandom, 0, NONE);
    endtask

    // Directed requests. After reset only knots 0..1 and rows 0..2 are searched.
    dir_req_t dir_tab [] = '{
        '{CMD_LOAD_KNOT, 7'd0,  32'h0000_0000, '0, '0, '0, '0, 0, NONE},
        '{CMD_LOAD_KNOT, 7'd1,  32'h0001_0000, '0, '0, '0, '0, 0, NONE},
        '{CMD_LOAD_ROW,  7'd0,  '0, '0, 32'h0001_0000, '0, '0, 0, NONE},
        '{CMD_LOAD_ROW,  7'd1,  '0, 32'h0001_0000, '0, '0, '0, 0, NONE},
        '{CMD_LOAD_ROW,  7'd2,  '0, '0, '0, '0, 32'h7FFF_FFFF, 0, NONE},
        // below the first knot: straight line of slope 1 from knot 0
        '{CMD_EVAL, 7'd0, 32'hFFFE_0000, '0, '0, '0, '0, 1,
          '{32'hFFFE_0000, 32'h0001_0000, '0, '0, 7'd0, 1'b0}},
        // exactly on knot 0 is segment 1
        '{CMD_EVAL, 7'd0, 32'h0000_0000, '0, '0, '0, '0, 1,
          '{32'h0001_0000, '0, '0, '0, 7'd1, 1'b0}},
        // on the last knot, largest cube coefficient: only the third derivative clips
        '{CMD_EVAL, 7'd0, 32'h0001_0000, '0, '0, '0, '0, 1,
          '{'0, '0, '0, 32'h7FFF_FFFF, 7'd2, 1'b1}},
        '{CMD_EVAL, 7'h7F, 32'h7FFF_FFFF, '0, '0, '0, '0, 0, NONE},
        '{CMD_EVAL, 7'h7F, 32'h8000_0000, '0, '0, '0, '0, 0, NONE},
        '{CMD_NONE, 7'h7F, 32'hFFFF_FFFF, '1, '1, '1, '1, 0, NONE},
        '{CMD_LOAD_KNOT, 7'd64, 32'h7FFF_FFFF, '0, '0, '0, '0, 0, NONE},
        '{CMD_LOAD_ROW, 7'h7F, '0, '1, '1, '1, '1, 0, NONE},
        '{CMD_LOAD_ROW,  7'd2,  '0, '0, '0, '0, 32'h8000_0000, 0, NONE},
        '{CMD_EVAL, 7'd0, 32'h0001_0000, '0, '0, '0, '0, 1,
          '{'0, '0, '0, 32'h8000_0000, 7'd2, 1'b1}},
        '{CMD_LOAD_ROW, 7'd1, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          0, NONE},
        '{CMD_EVAL, 7'd0, 32'h0000_8000, '0, '0, '0, '0, 0, NONE},
        '{CMD_EVAL, 7'd0, 32'h7FFF_FFFF, '0, '0, '0, '0, 0, NONE},
        // knots out of order: segment is still the count of knots not above x
        '{CMD_LOAD_KNOT, 7'd1, 32'hFFFF_0000, '0, '0, '0, '0, 0, NONE},
        '{CMD_EVAL, 7'd0, 32'hFFFF_8000, '0, '0, '0, '0, 0, NONE},
        '{CMD_LOAD_ROW, 7'd0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          0, NONE},
        '{CMD_EVAL, 7'd0, 32'h8000_0000, '0, '0, '0, '0, 0, NONE},
        '{CMD_LOAD_ROW, 7'd64, '0, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001, 32'hFFFF_FFFF,
          0, NONE}
    };

    // result side: random stalls, plus one long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                for (int c = 0; c < 3000; c++)
                    @(posedge clk);
                hold_req = 0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        spline_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
                report("unexpected result", '0, m_tdata[31:0]);
            else
            begin
                want = pending_q.pop_front();
                if (m_tdata[31:0] !== want.value)
                    report("value", want.value, m_tdata[31:0]);
                if (m_tdata[63:32] !== want.slope)
                    report("slope", want.slope, m_tdata[63:32]);
                if (m_tdata[95:64] !== want.curv)
                    report("curvature", want.curv, m_tdata[95:64]);
                if (m_tdata[127:96] !== want.third)
                    report("third", want.third, m_tdata[127:96]);
                if (m_tdata[134:128] !== want.seg)
                    report("segment", 32'(want.seg), 32'(m_tdata[134:128]));
                if (m_tuser !== want.sat)
                    report("saturated", 32'(want.sat), 32'(m_tuser));
                n_sat += want.sat;
            end
            n_checked++;
        end
    end

    initial
    begin
        logic [6:0] settings [6];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tuser     = '0;
        s_tdata     = '0;
        errors = 0; n_eval = 0; n_load = 0; n_drop = 0; n_checked = 0; n_sat = 0;
        cycles = 0;
        gaps_on  = 1;
        hold_req = 0;
        knot_count = 7'd2;
        for (int k = 0; k < MAX_KNOTS; k++)
            knot_mem[k] = '0;
        for (int r = 0; r <= MAX_KNOTS; r++)
            for (int c = 0; c < 4; c++)
                row_mem[r][c] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            offer(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].c0, dir_tab[i].c1,
                  dir_tab[i].c2, dir_tab[i].c3, dir_tab[i].typed, dir_tab[i].want);

        // every knot and row written before a wider search may read them
        load_tables();

        // register settings: both ends, the clamped ones beyond, and mid values
        settings = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd17, 7'($urandom_range(3, 63))};
        foreach (settings[p])
        begin
            set_knot_count(settings[p]);
            if (p == 3)
                load_tables();
            if (p == 5)
                gaps_on = 0;
            for (int i = 0; i < PHASE_REQS; i++)
            begin
                if (p == 1 && i == 20)
                    hold_req = 1;
                random_request();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d evaluates (%0d clipped), %0d table loads, %0d dropped requests",
                 n_eval, n_sat, n_load, n_drop);
        $display("over six knot-count settings including both clamped extremes, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
